// File: src/indexed_array_list_top_defines.svh
// Assertion macros for the indexed array list.
`ifndef INDEXED_ARRAY_LIST_TOP_DEFINES_SVH
`define INDEXED_ARRAY_LIST_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define IAL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define IAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ial_pkg.sv
package ial_pkg;

  localparam logic [3:0] OP_PUSH_FRONT = 4'd0;
  localparam logic [3:0] OP_PUSH_BACK  = 4'd1;
  localparam logic [3:0] OP_INSERT_AT  = 4'd2;
  localparam logic [3:0] OP_POP_FRONT  = 4'd3;
  localparam logic [3:0] OP_POP_BACK   = 4'd4;
  localparam logic [3:0] OP_REMOVE_AT  = 4'd5;
  localparam logic [3:0] OP_READ_AT    = 4'd6;
  localparam logic [3:0] OP_FIND       = 4'd7;
  localparam logic [3:0] OP_CLEAR      = 4'd8;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD      = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [6:0]  pad;
    logic [31:0] item_value;
    logic [4:0]  position;
    logic [3:0]  op;
  } req_t;

  typedef struct packed {
    logic [4:0]  pad;
    logic [4:0]  entry_count;
    logic [1:0]  status;
    logic [3:0]  found_position;
    logic [31:0] out_value;
  } res_t;

endpackage

// File: src/ial_ram.sv
module ial_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/indexed_array_list_top.sv
// Bounded ordered list of CAPACITY entries held in one single-port-write,
// registered-read RAM. Each input word carries one operation and yields one
// result word. Push, insert, pop, remove, read_at and find walk the RAM one
// entry per cycle; an operation reads at most CAPACITY entries, an append or
// a find on an empty list reads none, and clear and rejected operations skip
// the walk. The input is not ready while an operation is in progress; a
// finished result is loaded into the output register once that register is
// free, and the next word is taken in the cycle after. The RAM needs no
// clearing after reset: only entries below the count are ever read.
module indexed_array_list_top #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[3:0], position[8:4], item_value[40:9], zero fill
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_value[31:0], found_position[35:32], status[37:36], entry_count[42:38]
  output logic [47:0] m_axis_tdata
);

  import ial_pkg::*;

  `include "indexed_array_list_top_defines.svh"

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  localparam logic [1:0] MD_UP   = 2'd0;
  localparam logic [1:0] MD_DOWN = 2'd1;
  localparam logic [1:0] MD_READ = 2'd2;
  localparam logic [1:0] MD_FIND = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         cnt_new_q, cnt_new_d;
  logic [CW-1:0]         left_q, left_d;
  logic                  pipe_q, pipe_d;
  logic                  m_valid_q, m_valid_d;
  res_t                  m_data_q, m_data_d;
  logic [1:0]            mode_q, mode_d;
  logic [AW-1:0]         at_q, at_d;
  logic [AW-1:0]         ra_q, ra_d;
  logic [AW-1:0]         paddr_q, paddr_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [31:0]           value_q, value_d;
  logic [3:0]            found_q, found_d;
  logic [1:0]            status_q, status_d;
  logic                  hit_q, hit_d;

  req_t                  req;
  logic                  in_fire;
  logic [63:0]           in_ext;
  logic [63:0]           rd_ext;
  logic [CMPW-1:0]       cnt_x;
  logic [CMPW-1:0]       pos_x;
  logic [CMPW-1:0]       at_x;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [DATA_WIDTH-1:0] ram_rdata;

  assign req           = req_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_ext        = 64'($signed(req.item_value));
  assign rd_ext        = 64'($signed(ram_rdata));
  assign cnt_x         = CMPW'(count_q);
  assign pos_x         = CMPW'(req.position);

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = 48'(m_data_q);

  ial_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ra_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    cnt_new_d = cnt_new_q;
    left_d    = left_q;
    pipe_d    = pipe_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    mode_d    = mode_q;
    at_d      = at_q;
    ra_d      = ra_q;
    paddr_d   = paddr_q;
    val_d     = val_q;
    value_d   = value_q;
    found_d   = found_q;
    status_d  = status_q;
    hit_d     = hit_q;
    at_x      = '0;
    ram_we    = 1'b0;
    ram_waddr = at_q;
    ram_wdata = val_q;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          val_d     = in_ext[DATA_WIDTH-1:0];
          value_d   = '0;
          found_d   = '0;
          hit_d     = 1'b0;
          status_d  = ST_OK;
          cnt_new_d = count_q;
          left_d    = '0;
          state_d   = S_FINISH;
          case (req.op)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
              if (req.op == OP_PUSH_FRONT) begin
                at_x = '0;
              end else if (req.op == OP_PUSH_BACK) begin
                at_x = cnt_x;
              end else begin
                at_x = pos_x;
              end
              if (cnt_x >= CMPW'(CAPACITY)) begin
                status_d = ST_FULL;
              end else if (at_x > cnt_x) begin
                status_d = ST_BAD;
              end else begin
                mode_d    = MD_UP;
                at_d      = AW'(at_x);
                ra_d      = AW'(cnt_x - CMPW'(1));
                left_d    = CW'(cnt_x - at_x);
                cnt_new_d = count_q + CW'(1);
                state_d   = S_WALK;
              end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_AT, OP_READ_AT: begin
              if (req.op == OP_POP_FRONT) begin
                at_x = '0;
              end else if (req.op == OP_POP_BACK) begin
                at_x = (count_q != '0) ? cnt_x - CMPW'(1) : '0;
              end else begin
                at_x = pos_x;
              end
              if (count_q == '0 || at_x >= cnt_x) begin
                status_d = ST_BAD;
              end else begin
                at_d    = AW'(at_x);
                ra_d    = AW'(at_x);
                state_d = S_WALK;
                if (req.op == OP_READ_AT) begin
                  mode_d = MD_READ;
                  left_d = CW'(1);
                end else begin
                  mode_d    = MD_DOWN;
                  left_d    = CW'(cnt_x - at_x);
                  cnt_new_d = count_q - CW'(1);
                end
              end
            end
            OP_FIND: begin
              mode_d   = MD_FIND;
              ra_d     = '0;
              left_d   = count_q;
              status_d = ST_NOTFOUND;
              state_d  = S_WALK;
            end
            OP_CLEAR: begin
              cnt_new_d = '0;
            end
            default: begin
              status_d = ST_BAD;
            end
          endcase
        end
      end

      S_WALK: begin
        if (left_q != '0) begin
          ra_d    = (mode_q == MD_UP) ? ra_q - AW'(1) : ra_q + AW'(1);
          left_d  = left_q - CW'(1);
          pipe_d  = 1'b1;
          paddr_d = ra_q;
        end else begin
          pipe_d = 1'b0;
        end

        if (pipe_q) begin
          case (mode_q)
            MD_UP: begin
              ram_we    = 1'b1;
              ram_waddr = paddr_q + AW'(1);
              ram_wdata = ram_rdata;
            end
            MD_DOWN: begin
              if (paddr_q == at_q) begin
                value_d = rd_ext[31:0];
              end else begin
                ram_we    = 1'b1;
                ram_waddr = paddr_q - AW'(1);
                ram_wdata = ram_rdata;
              end
            end
            MD_READ: begin
              value_d = rd_ext[31:0];
            end
            default: begin
              if (!hit_q && ram_rdata == val_q) begin
                hit_d    = 1'b1;
                found_d  = 4'(paddr_q);
                status_d = ST_OK;
              end
            end
          endcase
        end

        if (left_q == '0 && !pipe_q) begin
          if (mode_q == MD_UP) begin
            ram_we    = 1'b1;
            ram_waddr = at_q;
            ram_wdata = val_q;
          end
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d               = 1'b1;
          m_data_d.pad            = '0;
          m_data_d.entry_count    = 5'(cnt_new_q);
          m_data_d.status         = status_q;
          m_data_d.found_position = found_q;
          m_data_d.out_value      = value_q;
          count_d                 = cnt_new_q;
          state_d                 = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      left_q    <= '0;
      pipe_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      left_q    <= left_d;
      pipe_q    <= pipe_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_new_q <= cnt_new_d;
    m_data_q  <= m_data_d;
    mode_q    <= mode_d;
    at_q      <= at_d;
    ra_q      <= ra_d;
    paddr_q   <= paddr_d;
    val_q     <= val_d;
    value_q   <= value_d;
    found_q   <= found_d;
    status_q  <= status_d;
    hit_q     <= hit_d;
  end

  `IAL_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CW'(CAPACITY), "count above capacity")
  `IAL_ASSERT_NEXT(a_accept_busy, in_fire, state_q != S_IDLE, "accepted word left block idle")
  `IAL_ASSERT_SAME(a_write_in_walk, ram_we, state_q == S_WALK, "RAM write outside walk")
  `IAL_ASSERT_NEXT(a_count_commit, state_q != S_FINISH, $stable(count_q), "count moved early")
  `IAL_ASSERT_SAME(a_pipe_in_walk, pipe_q, state_q == S_WALK, "read pending outside walk")

endmodule

// File: sim/indexed_array_list_top_test.sv
module indexed_array_list_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ial_pkg::*;

  localparam int          CAPACITY        = 16;
  localparam logic [3:0]  OP_FIRST_UNUSED = 4'd9;
  localparam logic [3:0]  OP_LAST_UNUSED  = 4'd15;
  localparam int          RANDOM_WORDS    = 700;
  localparam int          HOLD_CYCLES     = 300;
  localparam int          DRAIN_CYCLES    = 40;

  typedef struct packed {
    logic [3:0]  op;
    logic [4:0]  position;
    logic [31:0] item_value;
    logic [4:0]  reps;
    logic        typed;
    res_t        typed_res;
  } plan_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;

  logic [31:0] list_mem [CAPACITY];
  int unsigned list_fill = 0;

  res_t        list_results [$];
  plan_row_t   plan_rows [$];
  int unsigned fail_count      = 0;
  int unsigned words_sent      = 0;
  int unsigned directed_words  = 0;
  int unsigned results_checked = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};
  bit          calm_stretch    = 1'b0;
  bit          hold_req        = 1'b0;
  bit          hold_done       = 1'b0;

  indexed_array_list_top #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(32)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic res_t outcome(logic [31:0] v, logic [3:0] fp, logic [1:0] st,
                                   logic [4:0] cnt);
    res_t r;
    r = '0;
    r.out_value      = v;
    r.found_position = fp;
    r.status         = st;
    r.entry_count    = cnt;
    return r;
  endfunction

  function automatic void add_row(logic [3:0] op, logic [4:0] pos, logic [31:0] v,
                                  logic [4:0] reps, logic typed, res_t typed_res);
    plan_row_t row;
    row.op         = op;
    row.position   = pos;
    row.item_value = v;
    row.reps       = reps;
    row.typed      = typed;
    row.typed_res  = typed_res;
    plan_rows.push_back(row);
  endfunction

  function automatic res_t predict_word(req_t w);
    res_t        r;
    int unsigned at;
    int unsigned i;
    bit          hit;
    r        = '0;
    r.status = ST_OK;
    hit      = 1'b0;
    case (w.op)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT_AT: begin
        at = (w.op == OP_PUSH_FRONT) ? 0 : (w.op == OP_PUSH_BACK) ? list_fill : w.position;
        if (list_fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (at > list_fill) begin
          r.status = ST_BAD;
        end else begin
          for (i = list_fill; i > at; i--) list_mem[i] = list_mem[i-1];
          list_mem[at] = w.item_value;
          list_fill++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_AT, OP_READ_AT: begin
        at = (w.op == OP_POP_FRONT) ? 0
           : (w.op == OP_POP_BACK) ? ((list_fill != 0) ? list_fill - 1 : 0)
           : w.position;
        if (list_fill == 0 || at >= list_fill) begin
          r.status = ST_BAD;
        end else begin
          r.out_value = list_mem[at];
          if (w.op != OP_READ_AT) begin
            for (i = at; i + 1 < list_fill; i++) list_mem[i] = list_mem[i+1];
            list_fill--;
          end
        end
      end
      OP_FIND: begin
        r.status = ST_NOTFOUND;
        for (i = 0; i < list_fill; i++) begin
          if (!hit && list_mem[i] == w.item_value) begin
            hit              = 1'b1;
            r.found_position = 4'(i);
            r.status         = ST_OK;
          end
        end
      end
      OP_CLEAR: begin
        list_fill = 0;
      end
      default: begin
        r.status = ST_BAD;
      end
    endcase
    r.entry_count = 5'(list_fill);
    return r;
  endfunction

  task automatic send_word(req_t w, res_t want);
    while (!calm_stretch && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    list_results.push_back(want);
    words_sent++;
  endtask

  initial begin : result_checker
    res_t got;
    res_t want;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (list_results.size() == 0) begin
          $display("%0t ns: result with none expected: value %h pos %0d status %0d count %0d",
                   $time, got.out_value, got.found_position, got.status, got.entry_count);
          fail_count++;
        end else begin
          want = list_results.pop_front();
          results_checked++;
          if (got.out_value !== want.out_value || got.found_position !== want.found_position ||
              got.status !== want.status || got.entry_count !== want.entry_count) begin
            $display("%0t ns: mismatch expected value %h pos %0d status %0d count %0d",
                     $time, want.out_value, want.found_position, want.status,
                     want.entry_count);
            $display("%0t ns:          actual   value %h pos %0d status %0d count %0d",
                     $time, got.out_value, got.found_position, got.status, got.entry_count);
            fail_count++;
          end else begin
            status_seen[got.status]++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= (!calm_stretch && $urandom_range(99) < 17) ? 1'b0 : 1'b1;
    end
  end

  initial begin : stimulus
    plan_row_t   row;
    req_t        w;
    res_t        want;
    int unsigned k;
    int unsigned n;
    int unsigned pick;
    bit          grow;
    grow = 1'b1;

    add_row(OP_POP_FRONT, 5'd0, 32'h0, 5'd1, 1'b1, outcome(32'h0, 4'd0, ST_BAD, 5'd0));
    add_row(OP_POP_BACK, 5'd0, 32'h0, 5'd1, 1'b1, outcome(32'h0, 4'd0, ST_BAD, 5'd0));
    add_row(OP_REMOVE_AT, 5'd0, 32'h0, 5'd1, 1'b1, outcome(32'h0, 4'd0, ST_BAD, 5'd0));
    add_row(OP_READ_AT, 5'd0, 32'h0, 5'd1, 1'b1, outcome(32'h0, 4'd0, ST_BAD, 5'd0));
    add_row(OP_FIND, 5'd0, 32'h0, 5'd1, 1'b1, outcome(32'h0, 4'd0, ST_NOTFOUND, 5'd0));
    add_row(OP_INSERT_AT, 5'd1, 32'h5, 5'd1, 1'b1, outcome(32'h0, 4'd0, ST_BAD, 5'd0));
    add_row(OP_PUSH_BACK, 5'd0, 32'h7fffffff, 5'd1, 1'b1,
            outcome(32'h0, 4'd0, ST_OK, 5'd1));
    add_row(OP_PUSH_FRONT, 5'd31, 32'h80000000, 5'd1, 1'b1,
            outcome(32'h0, 4'd0, ST_OK, 5'd2));
    add_row(OP_INSERT_AT, 5'd1, 32'hffffffff, 5'd1, 1'b1,
            outcome(32'h0, 4'd0, ST_OK, 5'd3));
    add_row(OP_INSERT_AT, 5'd3, 32'h0, 5'd1, 1'b1, outcome(32'h0, 4'd0, ST_OK, 5'd4));
    add_row(OP_READ_AT, 5'd31, 32'h0, 5'd1, 1'b1, outcome(32'h0, 4'd0, ST_BAD, 5'd4));
    add_row(OP_REMOVE_AT, 5'd4, 32'h0, 5'd1, 1'b1, outcome(32'h0, 4'd0, ST_BAD, 5'd4));
    add_row(OP_FIND, 5'd0, 32'hffffffff, 5'd1, 1'b0, '0);
    add_row(OP_READ_AT, 5'd0, 32'h0, 5'd1, 1'b0, '0);
    add_row(OP_LAST_UNUSED, 5'd0, 32'h0, 5'd1, 1'b1, outcome(32'h0, 4'd0, ST_BAD, 5'd4));
    add_row(OP_FIRST_UNUSED, 5'd0, 32'h0, 5'd1, 1'b1, outcome(32'h0, 4'd0, ST_BAD, 5'd4));
    add_row(OP_POP_BACK, 5'd0, 32'h0, 5'd1, 1'b0, '0);
    add_row(OP_REMOVE_AT, 5'd1, 32'h0, 5'd1, 1'b0, '0);
    add_row(OP_POP_FRONT, 5'd0, 32'h0, 5'd1, 1'b0, '0);
    add_row(OP_PUSH_BACK, 5'd0, 32'h0, 5'd15, 1'b0, '0);
    add_row(OP_PUSH_FRONT, 5'd0, 32'h1, 5'd1, 1'b1, outcome(32'h0, 4'd0, ST_FULL, 5'd16));
    add_row(OP_INSERT_AT, 5'd16, 32'h2, 5'd1, 1'b1, outcome(32'h0, 4'd0, ST_FULL, 5'd16));
    add_row(OP_PUSH_BACK, 5'd0, 32'h3, 5'd1, 1'b1, outcome(32'h0, 4'd0, ST_FULL, 5'd16));
    add_row(OP_FIND, 5'd0, 32'h5a5a5a5a, 5'd1, 1'b0, '0);
    add_row(OP_REMOVE_AT, 5'd15, 32'h0, 5'd1, 1'b0, '0);
    add_row(OP_READ_AT, 5'd16, 32'h0, 5'd1, 1'b1, outcome(32'h0, 4'd0, ST_BAD, 5'd15));
    add_row(OP_CLEAR, 5'd0, 32'h0, 5'd1, 1'b1, outcome(32'h0, 4'd0, ST_OK, 5'd0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < plan_rows.size(); k++) begin
      row = plan_rows[k];
      for (n = 0; n < row.reps; n++) begin
        w            = '0;
        w.op         = row.op;
        w.position   = row.position;
        w.item_value = (row.reps > 1) ? $urandom : row.item_value;
        want = predict_word(w);
        if (row.typed) want = row.typed_res;
        send_word(w, want);
      end
    end
    directed_words = words_sent;

    for (k = 0; k < RANDOM_WORDS; k++) begin
      calm_stretch = (k >= 250 && k < 400);
      if (k == 450) hold_req = 1'b1;
      if (list_fill == CAPACITY) grow = 1'b0;
      if (list_fill == 0) grow = 1'b1;

      w    = '0;
      pick = $urandom_range(99);
      if (pick < 4) begin
        w.op = 4'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
      end else if (pick < 6) begin
        w.op = OP_CLEAR;
      end else if (pick < 16) begin
        w.op = OP_FIND;
      end else if (pick < 24) begin
        w.op = OP_READ_AT;
      end else if ((pick < 62) == grow) begin
        case ($urandom_range(2))
          0:       w.op = OP_PUSH_FRONT;
          1:       w.op = OP_PUSH_BACK;
          default: w.op = OP_INSERT_AT;
        endcase
      end else begin
        case ($urandom_range(2))
          0:       w.op = OP_POP_FRONT;
          1:       w.op = OP_POP_BACK;
          default: w.op = OP_REMOVE_AT;
        endcase
      end

      w.position = ($urandom_range(99) < 15) ? 5'($urandom_range(31))
                                             : 5'($urandom_range(list_fill));

      case ($urandom_range(9))
        0: begin
          case ($urandom_range(3))
            0:       w.item_value = 32'h00000000;
            1:       w.item_value = 32'h7fffffff;
            2:       w.item_value = 32'h80000000;
            default: w.item_value = 32'hffffffff;
          endcase
        end
        1, 2:    w.item_value = $urandom_range(3);
        default: w.item_value = $urandom;
      endcase
      if (w.op == OP_FIND && list_fill != 0 && $urandom_range(99) < 70)
        w.item_value = list_mem[$urandom_range(list_fill - 1)];

      send_word(w, predict_word(w));
    end
    calm_stretch = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (list_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d words (%0d directed, %0d random), checked %0d results.",
             words_sent, directed_words, words_sent - directed_words, results_checked);
    $display("Statuses seen: ok %0d, full %0d, bad position/empty %0d, not found %0d.",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BAD],
             status_seen[ST_NOTFOUND]);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Timeout at %0t ns with %0d results outstanding", $time, list_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
